// ===== hdl/animation_frame_sequencer_defines.svh =====
// assertion macros for the frame sequencer checker
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// checked property, held off while reset is asserted
`define AFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, also evaluated during reset
`define AFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/afs_pkg.sv =====
`timescale 1ns / 1ps
package afs_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 64;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned TARGET_W  = 6;
  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned LOADED_W  = 7;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned PASS_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [PASS_W-1:0] PASS_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_APPEND = 3'd1,
    OP_PLAY   = 3'd2,
    OP_STOP   = 3'd3,
    OP_GOTO   = 3'd4
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT = 2'd2;

  localparam logic [1:0] LOOP_RESTART  = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;

  typedef struct packed {
    logic [FRAME_W-1:0]  current_frame;
    logic                playing;
    logic                backward;
    logic                frame_changed;
    logic                ended;
    logic                rejected;
    logic [LOADED_W-1:0] frames_loaded;
  } result_t;

endpackage

// ===== hdl/afs_delay_mem.sv =====
`timescale 1ns / 1ps
module afs_delay_mem #(
  parameter int unsigned DEPTH = afs_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [afs_pkg::DELAY_W-1:0]      wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [afs_pkg::DELAY_W-1:0]      rd_data_o
);
  import afs_pkg::*;

  logic [DELAY_W-1:0] mem [DEPTH];
  logic [DELAY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/animation_frame_sequencer.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake                  | payload
// in       | input     | in_valid_i / in_ready_o    | operation, frame_delay, target_frame
// out      | output    | out_valid_o / out_ready_i  | current_frame .. frames_loaded
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item per cycle unless in_ready_o is low; its result is captured in the output register on the beat
// a reload leaves base speed and the table read pending; the registered ram read
// lands in time for the next item, so the countdown add happens on the next tick
// reset clears all control state; the delay table holds no reset value
// in_ready_o drops only while a result waits and out_ready_i is low
module animation_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [afs_pkg::OP_W-1:0]          operation_i,
  input  logic [afs_pkg::DELAY_W-1:0]       frame_delay_i,
  input  logic [afs_pkg::TARGET_W-1:0]      target_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [afs_pkg::FRAME_W-1:0]       current_frame_o,
  output logic                              playing_o,
  output logic                              backward_o,
  output logic                              frame_changed_o,
  output logic                              ended_o,
  output logic                              rejected_o,
  output logic [afs_pkg::LOADED_W-1:0]      frames_loaded_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afs_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import afs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned TOT_W = $clog2(MAX_FRAMES + 1);

  logic [DELAY_W-1:0]   base_speed_q;
  logic [1:0]           loop_mode_q;
  logic [CFG_DAT_W-1:0] loop_limit_q;

  logic [TOT_W-1:0]   total_q, total_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [DELAY_W-1:0] base_cap_q, base_cap_d;
  logic               run_q, run_d;
  logic               rev_q, rev_d;
  logic [PASS_W-1:0]  passes_q, passes_d;

  logic               out_valid_q;
  result_t            out_q, out_d;

  logic               in_fire;
  logic               wr_en;
  logic [DELAY_W-1:0] rd_delay;
  logic [COUNT_W-1:0] eff_cnt;
  logic               ended, rejected, at_last, cont;
  op_e                op;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign op          = op_e'(operation_i);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= '0;
      loop_mode_q  <= '0;
      loop_limit_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BASE_SPEED: base_speed_q <= cfg_data_i[DELAY_W-1:0];
        REG_LOOP_MODE:  loop_mode_q  <= cfg_data_i[1:0];
        REG_LOOP_LIMIT: loop_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  afs_delay_mem #(
    .DEPTH(MAX_FRAMES)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IDX_W'(total_q)),
    .wr_data_i (frame_delay_i),
    .rd_addr_i (idx_d),
    .rd_data_o (rd_delay)
  );

  // pending reload resolves to base speed plus the current frame's delay
  assign eff_cnt = pend_q ? (COUNT_W'(base_cap_q) + COUNT_W'(rd_delay)) : cnt_q;

  always_comb begin
    total_d    = total_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    base_cap_d = base_cap_q;
    run_d      = run_q;
    rev_d      = rev_q;
    passes_d   = passes_q;
    wr_en      = 1'b0;
    ended      = 1'b0;
    rejected   = 1'b0;
    cont       = 1'b0;
    at_last    = rev_q ? (idx_q == '0) : ((TOT_W'(idx_q) + TOT_W'(1)) >= total_q);
    if (in_fire) begin
      unique case (op)
        OP_TICK: begin
          if (run_q && (total_q != '0)) begin
            if (eff_cnt != '0) begin
              cnt_d  = eff_cnt - COUNT_W'(1);
              pend_d = 1'b0;
            end else if (at_last) begin
              if (loop_mode_q == LOOP_RESTART) begin
                idx_d = '0;
                cont  = 1'b1;
              end else if (loop_mode_q == LOOP_PINGPONG) begin
                rev_d = !rev_q;
                if (total_q > TOT_W'(1)) begin
                  if (!rev_q) begin
                    if (idx_q != '0) begin
                      idx_d = idx_q - IDX_W'(1);
                    end
                  end else if ((TOT_W'(idx_q) + TOT_W'(1)) < total_q) begin
                    idx_d = idx_q + IDX_W'(1);
                  end
                end
                cont = 1'b1;
              end else begin
                run_d    = 1'b0;
                cnt_d    = '0;
                pend_d   = 1'b0;
                passes_d = '0;
                ended    = 1'b1;
              end
              if (cont) begin
                if (passes_q != PASS_MAX) begin
                  passes_d = passes_q + PASS_W'(1);
                end
                if ((loop_limit_q != '0) && (passes_d > PASS_W'(loop_limit_q))) begin
                  run_d    = 1'b0;
                  cnt_d    = '0;
                  pend_d   = 1'b0;
                  passes_d = '0;
                  ended    = 1'b1;
                end else begin
                  pend_d     = 1'b1;
                  base_cap_d = base_speed_q;
                end
              end
            end else begin
              idx_d      = rev_q ? (idx_q - IDX_W'(1)) : (idx_q + IDX_W'(1));
              pend_d     = 1'b1;
              base_cap_d = base_speed_q;
            end
          end
        end
        OP_APPEND: begin
          if (total_q < TOT_W'(MAX_FRAMES)) begin
            wr_en   = 1'b1;
            total_d = total_q + TOT_W'(1);
          end else begin
            rejected = 1'b1;
          end
        end
        OP_PLAY: begin
          if (total_q == '0) begin
            rejected = 1'b1;
          end else begin
            if (!run_q) begin
              idx_d = '0;
            end
            run_d      = 1'b1;
            pend_d     = 1'b1;
            base_cap_d = base_speed_q;
          end
        end
        OP_STOP: begin
          if (total_q == '0) begin
            rejected = 1'b1;
          end else begin
            run_d    = 1'b0;
            cnt_d    = '0;
            pend_d   = 1'b0;
            passes_d = '0;
          end
        end
        OP_GOTO: begin
          if (32'(target_frame_i) >= 32'(total_q)) begin
            rejected = 1'b1;
          end else begin
            idx_d      = IDX_W'(target_frame_i);
            pend_d     = 1'b1;
            base_cap_d = base_speed_q;
          end
        end
        default: rejected = 1'b1;
      endcase
    end
  end

  always_comb begin
    out_d.current_frame = FRAME_W'(idx_d);
    out_d.playing       = run_d;
    out_d.backward      = rev_d;
    out_d.frame_changed = (idx_d != idx_q);
    out_d.ended         = ended;
    out_d.rejected      = rejected;
    out_d.frames_loaded = LOADED_W'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      base_cap_q  <= '0;
      run_q       <= 1'b0;
      rev_q       <= 1'b0;
      passes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q    <= total_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      base_cap_q <= base_cap_d;
      run_q      <= run_d;
      rev_q      <= rev_d;
      passes_q   <= passes_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_frame_o = out_q.current_frame;
  assign playing_o       = out_q.playing;
  assign backward_o      = out_q.backward;
  assign frame_changed_o = out_q.frame_changed;
  assign ended_o         = out_q.ended;
  assign rejected_o      = out_q.rejected;
  assign frames_loaded_o = out_q.frames_loaded;

endmodule

// ===== hdl/afs_checker.sv =====
`timescale 1ns / 1ps
`include "animation_frame_sequencer_defines.svh"
module afs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [afs_pkg::FRAME_W-1:0]       current_frame_o,
  input logic                              playing_o,
  input logic                              frame_changed_o,
  input logic                              ended_o,
  input logic                              rejected_o,
  input logic [afs_pkg::LOADED_W-1:0]      frames_loaded_o
);

  // stalled result beat holds
  `AFS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_frame_o) && $stable(frames_loaded_o), "result changed while stalled")

  // every accepted beat yields a result next cycle
  `AFS_ASSERT(a_in_to_out, in_valid_i && in_ready_o |=> out_valid_o, "no result after accepted beat")

  // an end of playback leaves the block stopped
  `AFS_ASSERT(a_ended_stops, out_valid_o && ended_o |-> !playing_o, "ended while still playing")

  // ignored commands never move the frame
  `AFS_ASSERT(a_reject_still, out_valid_o && rejected_o |-> !frame_changed_o && !ended_o, "rejected beat changed state")

  // playback needs a loaded table
  `AFS_ASSERT_ALWAYS(a_play_loaded, !rst_ni || !out_valid_o || !playing_o || (frames_loaded_o != '0), "playing with empty table")

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (.*);

// ===== test/animation_frame_sequencer_checker.sv =====
`timescale 1ns / 1ps
module animation_frame_sequencer_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [afs_pkg::OP_W-1:0]          operation_i,
  input  logic [afs_pkg::DELAY_W-1:0]       frame_delay_i,
  input  logic [afs_pkg::TARGET_W-1:0]      target_frame_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [afs_pkg::FRAME_W-1:0]       current_frame_i,
  input  logic                              playing_i,
  input  logic                              backward_i,
  input  logic                              frame_changed_i,
  input  logic                              ended_i,
  input  logic                              rejected_i,
  input  logic [afs_pkg::LOADED_W-1:0]      frames_loaded_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afs_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output int unsigned                       mismatches_o,
  output int unsigned                       pending_o
);
  import afs_pkg::*;

  logic [DELAY_W-1:0]  delay_mem [MAX_FRAMES_DEF];
  logic [LOADED_W-1:0] total_q;
  logic [FRAME_W-1:0]  index_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                run_q;
  logic                rev_q;
  logic [PASS_W-1:0]   passes_q;

  logic [7:0]          speed_q;
  logic [1:0]          mode_q;
  logic [15:0]         limit_q;

  result_t             frame_reports_q [$];
  int unsigned         mismatch_count = 0;

  function automatic logic [COUNT_W-1:0] reload_value();
    return COUNT_W'(speed_q) + COUNT_W'(delay_mem[index_q]);
  endfunction

  function automatic void halt_playback();
    run_q    = 1'b0;
    cnt_q    = '0;
    passes_q = '0;
  endfunction

  // end of sequence reached; returns 1 when playback stops here
  function automatic logic wrap_sequence();
    case (mode_q)
      LOOP_RESTART: index_q = '0;
      LOOP_PINGPONG: begin
        rev_q = !rev_q;
        if (total_q > 1) begin
          if (rev_q) begin
            if (index_q > 0) index_q--;
          end else if (index_q + 1 < total_q) begin
            index_q++;
          end
        end
      end
      default: begin
        halt_playback();
        return 1'b1;
      end
    endcase
    if (passes_q != PASS_MAX) passes_q++;
    if (limit_q != 0 && passes_q > PASS_W'(limit_q)) begin
      halt_playback();
      return 1'b1;
    end
    cnt_q = reload_value();
    return 1'b0;
  endfunction

  function automatic result_t step_sequence(logic [OP_W-1:0] op, logic [DELAY_W-1:0] dly,
                                            logic [TARGET_W-1:0] tgt);
    result_t            r;
    logic [FRAME_W-1:0] prior_frame;
    logic               stopped_now;
    logic               refused;
    prior_frame = index_q;
    stopped_now = 1'b0;
    refused     = 1'b0;
    case (op)
      OP_TICK: begin
        if (run_q && total_q != 0) begin
          if (cnt_q != 0) begin
            cnt_q--;
          end else if ((!rev_q && index_q + 1 >= total_q) || (rev_q && index_q == 0)) begin
            stopped_now = wrap_sequence();
          end else begin
            if (rev_q) index_q--;
            else index_q++;
            cnt_q = reload_value();
          end
        end
      end
      OP_APPEND: begin
        if (total_q < MAX_FRAMES_DEF) begin
          delay_mem[total_q[FRAME_W-1:0]] = dly;
          total_q++;
        end else begin
          refused = 1'b1;
        end
      end
      OP_PLAY: begin
        if (total_q == 0) begin
          refused = 1'b1;
        end else begin
          if (!run_q) index_q = '0;
          run_q = 1'b1;
          cnt_q = reload_value();
        end
      end
      OP_STOP: begin
        if (total_q == 0) refused = 1'b1;
        else halt_playback();
      end
      OP_GOTO: begin
        if (tgt >= total_q) begin
          refused = 1'b1;
        end else begin
          index_q = tgt;
          cnt_q   = reload_value();
        end
      end
      default: refused = 1'b1;
    endcase
    r.current_frame = index_q;
    r.playing       = run_q;
    r.backward      = rev_q;
    r.frame_changed = (index_q != prior_frame);
    r.ended         = stopped_now;
    r.rejected      = refused;
    r.frames_loaded = total_q;
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      total_q  = '0;
      index_q  = '0;
      cnt_q    = '0;
      run_q    = 1'b0;
      rev_q    = 1'b0;
      passes_q = '0;
      speed_q  = '0;
      mode_q   = '0;
      limit_q  = '0;
      frame_reports_q.delete();
      pending_o    <= 0;
      mismatches_o <= mismatch_count;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: result beat with no expectation, frame %0d", $time, current_frame_i);
          mismatch_count++;
        end else begin
          want = frame_reports_q.pop_front();
          check_field("current_frame", 8'(want.current_frame), 8'(current_frame_i));
          check_field("playing", 8'(want.playing), 8'(playing_i));
          check_field("backward", 8'(want.backward), 8'(backward_i));
          check_field("frame_changed", 8'(want.frame_changed), 8'(frame_changed_i));
          check_field("ended", 8'(want.ended), 8'(ended_i));
          check_field("rejected", 8'(want.rejected), 8'(rejected_i));
          check_field("frames_loaded", 8'(want.frames_loaded), 8'(frames_loaded_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BASE_SPEED: speed_q = cfg_data_i[7:0];
          REG_LOOP_MODE:  mode_q  = cfg_data_i[1:0];
          REG_LOOP_LIMIT: limit_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want = step_sequence(operation_i, frame_delay_i, target_frame_i);
        frame_reports_q = {frame_reports_q, want};
      end
      pending_o    <= frame_reports_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

// ===== test/animation_frame_sequencer_test.sv =====
`timescale 1ns / 1ps
module animation_frame_sequencer_test;
  import afs_pkg::*;

  localparam int unsigned ITEMS          = 1500;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;
  localparam logic [1:0]           LOOP_STOP       = 2'd0;
  localparam logic [OP_W-1:0]      OP_FIRST_UNUSED = 3'd5;

  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid     = 1'b0;
  logic [OP_W-1:0]       operation    = '0;
  logic [DELAY_W-1:0]    frame_delay  = '0;
  logic [TARGET_W-1:0]   target_frame = '0;
  logic                  out_ready    = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DAT_W-1:0]  cfg_data     = '0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  cfg_ready_o;
  logic [FRAME_W-1:0]    current_frame_o;
  logic                  playing_o;
  logic                  backward_o;
  logic                  frame_changed_o;
  logic                  ended_o;
  logic                  rejected_o;
  logic [LOADED_W-1:0]   frames_loaded_o;

  int unsigned           mismatches;
  int unsigned           results_pending;
  int unsigned           sent_items   = 0;
  int unsigned           appended     = 0;
  int unsigned           idle_cycles  = 0;
  logic                  tx_quiet     = 1'b0;
  logic                  rx_quiet     = 1'b0;

  animation_frame_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation),
    .frame_delay_i   (frame_delay),
    .target_frame_i  (target_frame),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .current_frame_o (current_frame_o),
    .playing_o       (playing_o),
    .backward_o      (backward_o),
    .frame_changed_o (frame_changed_o),
    .ended_o         (ended_o),
    .rejected_o      (rejected_o),
    .frames_loaded_o (frames_loaded_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  animation_frame_sequencer_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation),
    .frame_delay_i   (frame_delay),
    .target_frame_i  (target_frame),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready),
    .current_frame_i (current_frame_o),
    .playing_i       (playing_o),
    .backward_i      (backward_o),
    .frame_changed_i (frame_changed_o),
    .ended_i         (ended_o),
    .rejected_i      (rejected_o),
    .frames_loaded_i (frames_loaded_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .pending_o       (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DELAY_W-1:0] dly,
                           input logic [TARGET_W-1:0] tgt);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    frame_delay  <= dly;
    target_frame <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (op == OP_APPEND && appended < MAX_FRAMES_DEF) appended++;
  endtask

  task automatic pause_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // unused data bits carry noise
  task automatic configure(input logic [7:0] speed, input logic [1:0] mode,
                           input logic [15:0] limit);
    write_reg(REG_BASE_SPEED, {8'($urandom), speed});
    write_reg(REG_LOOP_MODE, {14'($urandom), mode});
    write_reg(REG_LOOP_LIMIT, limit);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned        phase_len;
    int unsigned        pick;
    logic [7:0]         speed;
    logic [15:0]        limit;
    logic [OP_W-1:0]    op;
    logic [DELAY_W-1:0] dly;
    logic [TARGET_W-1:0] tgt;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send_item(OP_TICK, 8'h00, 6'h00);
    send_item(OP_PLAY, 8'h00, 6'h00);
    send_item(OP_STOP, 8'h00, 6'h00);
    send_item(OP_GOTO, 8'h00, 6'h00);
    for (int k = OP_FIRST_UNUSED; k < (1 << OP_W); k++)
      send_item(OP_W'(k), 8'hFF, 6'h3F);

    pause_for_results();
    configure(8'd0, LOOP_PINGPONG, 16'd0);
    // single frame ping-pong, then two frames
    send_item(OP_APPEND, 8'h00, 6'h00);
    send_item(OP_PLAY, 8'h00, 6'h00);
    send_item(OP_TICK, 8'h00, 6'h00);
    send_item(OP_TICK, 8'h00, 6'h00);
    send_item(OP_GOTO, 8'h00, 6'h3F);
    send_item(OP_APPEND, 8'hFF, 6'h00);
    send_item(OP_GOTO, 8'h00, 6'h01);
    send_item(OP_STOP, 8'h00, 6'h00);
    send_item(OP_PLAY, 8'h00, 6'h00);
    send_item(OP_TICK, 8'h00, 6'h00);
    send_item(OP_PLAY, 8'h00, 6'h00);
    send_item(OP_GOTO, 8'h00, 6'h00);
    send_item(OP_STOP, 8'h00, 6'h00);

    pause_for_results();
    configure(8'hFF, LOOP_RESTART, 16'hFFFF);
    send_item(OP_PLAY, 8'h00, 6'h00);
    send_item(OP_TICK, 8'h00, 6'h00);
    send_item(OP_TICK, 8'h00, 6'h00);

    while (sent_items < ITEMS) begin
      pause_for_results();
      pick = $urandom_range(0, 7);
      speed = (pick == 0) ? 8'($urandom) : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 2));
      pick = $urandom_range(0, 7);
      if (pick < 2) limit = 16'd0;
      else if (pick < 6) limit = 16'($urandom_range(1, 3));
      else if (pick == 6) limit = 16'($urandom);
      else limit = 16'hFFFF;
      configure(speed, 2'($urandom_range(LOOP_STOP, 3)), limit);
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      send_item(OP_PLAY, 8'($urandom), 6'($urandom));
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        dly  = 8'($urandom);
        tgt  = 6'($urandom);
        if (pick < 6) begin
          op = OP_APPEND;
          if ($urandom_range(0, 9) != 0) dly = 8'($urandom_range(0, 3));
        end else if (pick < 11) begin
          op = OP_PLAY;
        end else if (pick < 14) begin
          op = OP_STOP;
        end else if (pick < 19) begin
          op = OP_GOTO;
          if (appended > 0 && $urandom_range(0, 3) != 0)
            tgt = 6'($urandom_range(0, appended - 1));
        end else if (pick < 21) begin
          op = OP_W'($urandom_range(OP_FIRST_UNUSED, (1 << OP_W) - 1));
        end else begin
          op = OP_TICK;
        end
        send_item(op, dly, tgt);
      end
    end

    pause_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
